/* hw/rtl/crout_pkg.sv */
package crout_pkg;

  localparam int MaxOrder = 8;
  localparam int FracBits = 16;
  localparam int SizeW = 4;
  localparam int ValW = 32;
  localparam int SumW = 64;
  localparam logic [SizeW-1:0] SizeReset = 4'd8;

  function automatic logic signed [ValW-1:0] sat32(input logic signed [SumW+1:0] v,
                                                   output logic ovf);
    logic signed [SumW+1:0] hi;
    logic signed [SumW+1:0] lo;
    hi = (SumW+2)'(32'sh7fffffff);
    lo = -(SumW+2)'(64'sh80000000);
    ovf = 1'b0;
    if (v > hi) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < lo) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[ValW-1:0];
  endfunction

endpackage

/* hw/rtl/crout_ram.sv */
module crout_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/crout_div.sv */
// Unsigned restoring divider, one quotient bit per cycle.
module crout_div
  import crout_pkg::*;
#(
  parameter int NumW = 64,
  parameter int DenW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            busy,
  output logic [NumW-1:0] quo
);

  logic [NumW-1:0] rem;
  logic [DenW-1:0] dv;
  logic [$clog2(NumW+1)-1:0] cnt;
  logic [NumW:0] trial;

  assign trial = {rem, quo[NumW-1]} - {{(NumW+1-DenW){1'b0}}, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= ($clog2(NumW+1))'(NumW);
      quo <= num;
      rem <= '0;
      dv <= den;
    end else if (busy) begin
      if (trial[NumW]) begin
        rem <= {rem[NumW-2:0], quo[NumW-1]};
        quo <= {quo[NumW-2:0], 1'b0};
      end else begin
        rem <= trial[NumW-1:0];
        quo <= {quo[NumW-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == 1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/crout_lu_decomposition_top.sv */
// Crout LU decomposition of an n-by-n Q16.16 matrix (n from matrix_size, 1..8).
// Elements are taken in row-major order, one word per cycle while cfg_valid is
// low. The last element starts the decomposition; no input is taken until all
// n*n result words are delivered in row-major order. Each L or U entry passes
// each inner multiply-accumulate term through memory read, multiply and
// accumulate steps, and each U entry that needs the serial divider then waits
// for it. Each result word then goes through memory read, present and
// handshake steps, and waits while the sink holds off. The source and
// factor matrices live in three 64-entry RAMs.
module crout_lu_decomposition_top
  import crout_pkg::*;
#(
  parameter int MAX_ORDER = MaxOrder,
  parameter int FRAC_BITS = FracBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // element_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // row, col, lower, upper, pad
  output logic [1:0]  m_axis_tuser,   // singular_flag, saturated_flag
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int IdxW = $clog2(MAX_ORDER);
  localparam int AW = 2 * IdxW;
  localparam int Depth = 1 << AW;

  localparam logic [3:0] S_LOAD = 4'd0, S_INIT = 4'd1, S_RD = 4'd2, S_MUL = 4'd3,
                         S_ACC = 4'd4, S_PIV = 4'd5, S_PIV2 = 4'd6, S_DIV = 4'd7,
                         S_DIVW = 4'd8, S_OUTR = 4'd9, S_OUTW = 4'd10, S_OUT = 4'd11,
                         S_WR = 4'd12;

  logic [3:0] state;
  logic [SizeW-1:0] size_reg;
  logic [IdxW:0] n;
  logic [IdxW-1:0] lr, lc, i, j, k, lim;
  logic signed [SumW-1:0] sum;
  logic signed [2*ValW-1:0] prod;
  logic sing, satf;
  logic [AW-1:0] a_ra, l_ra, u_ra, l_wa, u_wa;
  logic a_we, l_we, u_we;
  logic [ValW-1:0] a_rd, l_rd, u_rd, l_wd, u_wd, a_hold, piv;
  logic div_start, div_busy;
  logic [SumW-1:0] div_num, div_quo;
  logic [ValW-1:0] div_den;
  logic neg;
  logic signed [SumW+1:0] diff;
  logic [SumW+1:0] mag;
  logic ovf;
  logic signed [ValW-1:0] lsat;
  logic [IdxW-1:0] orow, ocol;
  logic [ValW-1:0] olo, oup;
  logic olast;
  logic nz, nbig;
  logic div_big;
  logic wr_now;

  assign nz = (size_reg == '0);
  assign nbig = (size_reg > SizeW'(MAX_ORDER));
  assign n = nz ? (IdxW+1)'(1) : nbig ? (IdxW+1)'(MAX_ORDER) : size_reg[IdxW:0];
  assign cfg_ready = (state == S_LOAD);
  assign s_axis_tready = (state == S_LOAD) && !cfg_valid;
  assign lim = (i < j) ? i : j;

  crout_ram #(.Width(ValW), .Depth(Depth)) u_a (.clk, .we(a_we), .waddr({lr, lc}),
    .wdata(s_axis_tdata), .raddr(a_ra), .rdata(a_rd));
  crout_ram #(.Width(ValW), .Depth(Depth)) u_l (.clk, .we(l_we), .waddr(l_wa),
    .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  crout_ram #(.Width(ValW), .Depth(Depth)) u_u (.clk, .we(u_we), .waddr(u_wa),
    .wdata(u_wd), .raddr(u_ra), .rdata(u_rd));
  crout_div #(.NumW(SumW), .DenW(ValW)) u_div (.clk, .rst, .start(div_start),
    .num(div_num), .den(div_den), .busy(div_busy), .quo(div_quo));

  assign a_we = s_axis_tvalid && s_axis_tready;
  assign a_ra = {i, j};
  assign diff = (SumW+2)'(signed'(a_hold)) - (SumW+2)'(sum);
  assign mag = diff[SumW+1] ? -diff : diff;
  assign neg = diff[SumW+1] ^ piv[ValW-1];
  assign div_big = mag >= ((SumW+2)'(1) << (62 - FRAC_BITS));
  assign wr_now = (state == S_WR) || ((state == S_DIV) && ((piv == '0) || div_big)) ||
                  ((state == S_DIVW) && !div_busy && !div_start);

  always_comb begin
    lsat = sat32(diff, ovf);
  end

  always_comb begin
    l_ra = {i, k};
    u_ra = {k, j};
    if (state == S_PIV || state == S_PIV2) begin
      l_ra = {i, i};
    end
    if (state == S_OUTR || state == S_OUTW || state == S_OUT) begin
      l_ra = {orow, ocol};
      u_ra = {orow, ocol};
    end
  end

  always_ff @(posedge clk) begin
    prod <= signed'(l_rd) * signed'(u_rd);
  end

  logic [SumW-1:0] q;
  logic [ValW-1:0] dq;
  logic dovf;
  always_comb begin
    q = div_quo;
    dovf = 1'b0;
    if (neg) begin
      if (q > (SumW'(1) << 31)) begin
        dovf = 1'b1;
        dq = 32'h80000000;
      end else begin
        dq = 32'(-q);
      end
    end else if (q > SumW'(32'h7fffffff)) begin
      dovf = 1'b1;
      dq = 32'h7fffffff;
    end else begin
      dq = q[ValW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l_we <= 1'b0;
      u_we <= 1'b0;
      div_start <= 1'b0;
    end else begin
      l_we <= wr_now;
      u_we <= wr_now;
      div_start <= (state == S_DIV) && (piv != '0) && !div_big;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      size_reg <= SizeReset;
      lr <= '0;
      lc <= '0;
      sing <= 1'b0;
      satf <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (cfg_valid) begin
            size_reg <= cfg_data;
            lr <= '0;
            lc <= '0;
          end else if (a_we) begin
            if ({1'b0, lc} == n - 1'b1) begin
              lc <= '0;
              if ({1'b0, lr} == n - 1'b1) begin
                lr <= '0;
                state <= S_INIT;
                sing <= 1'b0;
                satf <= 1'b0;
                i <= '0;
                j <= '0;
              end else begin
                lr <= lr + 1'b1;
              end
            end else begin
              lc <= lc + 1'b1;
            end
          end
        end
        S_INIT: begin
          k <= '0;
          sum <= '0;
          state <= (lim == '0) ? S_PIV : S_RD;
        end
        S_RD: state <= S_MUL;
        S_MUL: state <= S_ACC;
        S_ACC: begin
          sum <= sum + (prod >>> FRAC_BITS);
          if (k + 1'b1 == lim) begin
            state <= S_PIV;
          end else begin
            k <= k + 1'b1;
            state <= S_RD;
          end
        end
        S_PIV: state <= S_PIV2;
        S_PIV2: begin
          a_hold <= a_rd;
          piv <= l_rd;
          state <= (i < j) ? S_DIV : S_WR;
        end
        S_WR: begin
          l_wa <= {i, j};
          u_wa <= {i, j};
          l_wd <= lsat;
          u_wd <= (i == j) ? ValW'(1) << FRAC_BITS : '0;
          if (ovf) satf <= 1'b1;
          state <= S_OUTW;
        end
        S_DIV: begin
          l_wa <= {i, j};
          u_wa <= {i, j};
          l_wd <= '0;
          if (piv == '0) begin
            sing <= 1'b1;
            u_wd <= '0;
            state <= S_OUTW;
          end else if (div_big) begin
            satf <= 1'b1;
            u_wd <= neg ? 32'h80000000 : 32'h7fffffff;
            state <= S_OUTW;
          end else begin
            div_num <= mag[SumW-1:0] << FRAC_BITS;
            div_den <= piv[ValW-1] ? 32'(-piv) : piv;
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (!div_busy && !div_start) begin
            u_wd <= dq;
            if (dovf) satf <= 1'b1;
            state <= S_OUTW;
          end
        end
        S_OUTW: begin
          if ({1'b0, j} == n - 1'b1) begin
            j <= '0;
            if ({1'b0, i} == n - 1'b1) begin
              orow <= '0;
              ocol <= '0;
              state <= S_OUTR;
            end else begin
              i <= i + 1'b1;
              state <= S_INIT;
            end
          end else begin
            j <= j + 1'b1;
            state <= S_INIT;
          end
        end
        S_OUTR: state <= S_OUT;
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            olo <= l_rd;
            oup <= u_rd;
            olast <= ({1'b0, orow} == n - 1'b1) && ({1'b0, ocol} == n - 1'b1);
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (olast) begin
              state <= S_LOAD;
            end else begin
              if ({1'b0, ocol} == n - 1'b1) begin
                ocol <= '0;
                orow <= orow + 1'b1;
              end else begin
                ocol <= ocol + 1'b1;
              end
              state <= S_OUTR;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, oup, olo, 3'(ocol), 3'(orow)};
  assign m_axis_tuser = {satf, sing};
  assign m_axis_tlast = olast;

  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !s_axis_tready) else $error("input taken while busy");
  a_out_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (state == S_OUT)) else $error("result outside output phase");
  a_last_back: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (state == S_LOAD))
    else $error("no return to load");

endmodule
